@@ design/bspline_basis_weights_unit_defines.svh @@
`ifndef BSPLINE_BASIS_WEIGHTS_UNIT_DEFINES_SVH
`define BSPLINE_BASIS_WEIGHTS_UNIT_DEFINES_SVH

// Checked on the rising clock edge, held off while reset is high.
`define BBW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on the rising clock edge at all times, reset included.
`define BBW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bbw_pkg.sv @@
`timescale 1ns / 1ps

package bbw_pkg;

  localparam int MAX_ORDER_DEF = 6;
  localparam int MAX_KNOTS_DEF = 64;

  localparam int KNOT_W = 32;
  localparam int WGT_W  = 17;
  localparam int SLOT_W = 3;
  localparam int IX_W   = 11;   // signed knot index arithmetic
  localparam int NUM_W  = 48;   // |diff| * basis magnitude
  localparam int TERM_W = NUM_W + 2;

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  localparam logic [1:0] REG_DEGREE      = 2'd0;
  localparam logic [1:0] REG_POINT_COUNT = 2'd1;
  localparam logic [1:0] REG_KNOT_COUNT  = 2'd2;

  localparam logic [2:0] DEGREE_RST      = 3'd3;
  localparam logic [5:0] POINT_COUNT_RST = 6'd4;
  localparam logic [6:0] KNOT_COUNT_RST  = 7'd8;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LO, ST_CHK, ST_HI, ST_INIT, ST_STEP, ST_POS,
    ST_RDA, ST_RDB, ST_RDC, ST_RDD, ST_MUL_A, ST_GO_A, ST_WAIT_A,
    ST_MUL_B, ST_GO_B, ST_WAIT_B, ST_NEXT, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_STORE, OP_BEGIN, OP_LO_CAPTURE, OP_SRCH_READ, OP_SRCH_TEST,
    OP_INIT, OP_STEP_BEGIN, OP_POS_READ, OP_SHIFT, OP_RDA, OP_RDB, OP_RDC,
    OP_RDD, OP_MUL_A, OP_MUL_B, OP_DIV_GO, OP_TERM_A, OP_UPDATE,
    OP_STEP_INC, OP_FINAL, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_ok;
    logic hit;
    logic pos_active;
    logic pos_last;
    logic step_last;
    logic emit_last;
    logic div_done;
  } dp_status_t;

endpackage

@@ design/bbw_divider.sv @@
`timescale 1ns / 1ps

module bbw_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [bbw_pkg::NUM_W-1:0]   num,
  input  logic [bbw_pkg::KNOT_W-1:0]  den,
  output logic                        done,
  output logic [bbw_pkg::NUM_W-1:0]   quo
);
  import bbw_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [KNOT_W-1:0] rem;
  logic [KNOT_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [KNOT_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (run) begin
      if (fits) begin
        rem <= KNOT_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[KNOT_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ design/bbw_datapath.sv @@
`timescale 1ns / 1ps

module bbw_datapath #(
  parameter int MAX_ORDER = bbw_pkg::MAX_ORDER_DEF,
  parameter int MAX_KNOTS = bbw_pkg::MAX_KNOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bbw_pkg::dp_cmd_t             cmd,
  output bbw_pkg::dp_status_t          status,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [6:0]                   cfg_data,
  input  logic [5:0]                   knot_slot,
  input  logic [bbw_pkg::KNOT_W-1:0]   value,
  output logic                         result_valid,
  output logic [5:0]                   start_index,
  output logic [bbw_pkg::SLOT_W-1:0]   basis_slot,
  output logic [bbw_pkg::WGT_W-1:0]    weight,
  output logic                         last
);
  import bbw_pkg::*;

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;

  // configuration
  logic [2:0] curve_degree;
  logic [5:0] wrapped_point_count;
  logic [6:0] knot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree        <= DEGREE_RST;
      wrapped_point_count <= POINT_COUNT_RST;
      knot_count          <= KNOT_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEGREE:      curve_degree        <= cfg_data[2:0];
        REG_POINT_COUNT: wrapped_point_count <= cfg_data[5:0];
        REG_KNOT_COUNT:  knot_count          <= cfg_data;
        default: ;
      endcase
    end
  end

  // evaluation registers
  logic [KNOT_W-1:0]      t;
  logic [2:0]             deg;
  logic [2:0]             order;
  logic signed [IX_W-1:0] wpc_deg;
  logic signed [IX_W-1:0] kc;
  logic signed [IX_W-1:0] i;
  logic signed [IX_W-1:0] start;
  logic signed [IX_W-1:0] end_ix;
  logic [2:0]             step;
  logic [SLOT_W-1:0]      p;
  logic [KNOT_W-1:0]      lo, ka, kb, kc1, kd;
  logic [WGT_W-1:0]       b [MAX_ORDER];
  logic [NUM_W-1:0]       prod;
  logic [KNOT_W-1:0]      den_mag;
  logic                   neg, zero;
  logic signed [TERM_W-1:0] term_a;

  // knot store
  logic [KNOT_W-1:0]      mem [MAX_KNOTS];
  logic [KNOT_W-1:0]      rdata;
  logic                   oob_q;
  logic signed [IX_W-1:0] rd_ix;
  logic                   rd_oob;
  logic signed [IX_W-1:0] slot_ix;
  logic [KNOT_W-1:0]      kval;

  assign slot_ix = IX_W'(knot_slot);
  assign rd_oob  = (rd_ix < 0) || (rd_ix >= IX_W'(MAX_KNOTS));
  assign kval    = oob_q ? '0 : rdata;

  always_comb begin
    case (cmd.op)
      OP_SRCH_READ: rd_ix = i + IX_W'(1);
      OP_POS_READ:  rd_ix = start + IX_W'(p);
      OP_RDA:       rd_ix = start + IX_W'(p) + IX_W'(step) - IX_W'(1);
      OP_RDB:       rd_ix = start + IX_W'(p) + IX_W'(1);
      OP_RDC:       rd_ix = start + IX_W'(p) + IX_W'(step);
      default:      rd_ix = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && slot_ix < IX_W'(MAX_KNOTS)) begin
      mem[slot_ix[AW-1:0]] <= value;
    end
    rdata <= mem[rd_ix[AW-1:0]];
    oob_q <= rd_oob;
  end

  // clamped degree and knot count from the registers
  logic [2:0]             deg_c;
  logic signed [IX_W-1:0] kc_c;

  always_comb begin
    deg_c = curve_degree;
    if (curve_degree == 3'd0) deg_c = 3'd1;
    if (curve_degree > 3'(MAX_ORDER - 1)) deg_c = 3'(MAX_ORDER - 1);
    kc_c = IX_W'(knot_count);
    if (kc_c > IX_W'(MAX_KNOTS)) kc_c = IX_W'(MAX_KNOTS);
  end

  // active count of the current step, 0..order
  logic signed [IX_W-1:0] cnt_raw;
  logic [2:0]             count;

  always_comb begin
    cnt_raw = end_ix - start + IX_W'(1);
    if (cnt_raw < 0) count = 3'd0;
    else if (cnt_raw > IX_W'(order)) count = order;
    else count = cnt_raw[2:0];
  end

  logic signed [IX_W-1:0] i_less_deg;
  assign i_less_deg = i - IX_W'(deg);

  // term operands
  logic signed [KNOT_W:0] diff, den;
  logic [KNOT_W-1:0]      diff_mag;
  logic [WGT_W-1:0]       bsel;
  logic [WGT_W-1:0]       b_next;

  assign b_next = (p == SLOT_W'(MAX_ORDER - 1)) ? '0 : b[1];

  always_comb begin
    if (cmd.op == OP_MUL_B) begin
      diff = $signed({1'b0, kd}) - $signed({1'b0, t});
      den  = $signed({1'b0, kd}) - $signed({1'b0, kc1});
      bsel = b_next;
    end else begin
      diff = $signed({1'b0, t}) - $signed({1'b0, ka});
      den  = $signed({1'b0, kb}) - $signed({1'b0, ka});
      bsel = b[0];
    end
    diff_mag = diff[KNOT_W] ? KNOT_W'(-diff) : diff[KNOT_W-1:0];
  end

  logic [NUM_W-1:0]         quo;
  logic                     div_done;
  logic signed [TERM_W-1:0] term_now;
  logic signed [TERM_W:0]   sum;
  logic [WGT_W-1:0]         sum_sat;

  always_comb begin
    if (zero) term_now = '0;
    else if (neg) term_now = -$signed({2'b00, quo});
    else term_now = $signed({2'b00, quo});
    sum = (TERM_W+1)'(term_a) + (TERM_W+1)'(term_now);
    if (sum < 0) sum_sat = '0;
    else if (sum > (TERM_W+1)'(ONE_Q16)) sum_sat = ONE_Q16;
    else sum_sat = sum[WGT_W-1:0];
  end

  bbw_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.op == OP_DIV_GO),
    .num  (prod),
    .den  (den_mag),
    .done (div_done),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BEGIN: begin
        t       <= value;
        deg     <= deg_c;
        order   <= deg_c + 3'd1;
        wpc_deg <= IX_W'(wrapped_point_count) + IX_W'(deg_c);
        kc      <= kc_c;
        i       <= '0;
        start   <= '0;
        end_ix  <= '0;
      end
      OP_LO_CAPTURE: lo <= kval;
      OP_SRCH_TEST: begin
        if (status.hit) begin
          start  <= (i_less_deg > 0) ? i_less_deg : '0;
          end_ix <= i;
        end else begin
          lo <= kval;
          i  <= i + IX_W'(1);
        end
      end
      OP_INIT: begin
        for (int j = 0; j < MAX_ORDER; j++) begin
          b[j] <= (IX_W'(j) == end_ix - start) ? ONE_Q16 : '0;
        end
        step <= 3'd2;
      end
      OP_STEP_BEGIN: begin
        if (end_ix + IX_W'(step) >= kc) end_ix <= wpc_deg - IX_W'(step);
        p <= '0;
      end
      OP_SHIFT: begin
        for (int j = 0; j < MAX_ORDER - 1; j++) b[j] <= b[j+1];
        b[MAX_ORDER-1] <= b[0];
        p <= p + 1'b1;
      end
      OP_RDA: ka  <= kval;
      OP_RDB: kb  <= kval;
      OP_RDC: kc1 <= kval;
      OP_RDD: kd  <= kval;
      OP_MUL_A, OP_MUL_B: begin
        prod    <= NUM_W'(diff_mag * bsel);
        den_mag <= den[KNOT_W] ? KNOT_W'(-den) : den[KNOT_W-1:0];
        neg     <= diff[KNOT_W] ^ den[KNOT_W];
        zero    <= (bsel == '0) || (den == '0);
      end
      OP_TERM_A: term_a <= term_now;
      OP_UPDATE: begin
        for (int j = 0; j < MAX_ORDER - 1; j++) b[j] <= b[j+1];
        b[MAX_ORDER-1] <= sum_sat;
        p <= p + 1'b1;
      end
      OP_STEP_INC: step <= step + 3'd1;
      OP_FINAL: begin
        for (int j = 0; j < MAX_ORDER; j++) begin
          if (3'(j) >= count) b[j] <= '0;
        end
        p <= '0;
      end
      OP_EMIT: begin
        for (int j = 0; j < MAX_ORDER - 1; j++) b[j] <= b[j+1];
        b[MAX_ORDER-1] <= b[0];
        p <= p + 1'b1;
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == OP_EMIT);
    end
    if (cmd.op == OP_EMIT) begin
      start_index <= start[5:0];
      basis_slot  <= p;
      weight      <= b[0];
      last        <= status.emit_last;
    end
  end

  always_comb begin
    status.srch_ok    = (i < wpc_deg) && (i + IX_W'(1) < kc);
    status.hit        = (lo != kval) && (t >= lo) && (t <= kval);
    status.pos_active = 3'(p) < count;
    status.pos_last   = p == SLOT_W'(MAX_ORDER - 1);
    status.step_last  = step == order;
    status.emit_last  = 3'(p) == order - 3'd1;
    status.div_done   = div_done;
  end

endmodule

@@ design/bbw_ctrl.sv @@
`timescale 1ns / 1ps

module bbw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  output logic                busy,
  output bbw_pkg::dp_cmd_t    cmd,
  input  bbw_pkg::dp_status_t status
);
  import bbw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation) begin
            cmd.op     = OP_BEGIN;
            state_next = ST_LO;
          end else begin
            cmd.op = OP_STORE;
          end
        end
      end
      ST_LO: begin
        cmd.op     = OP_LO_CAPTURE;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (status.srch_ok) begin
          cmd.op     = OP_SRCH_READ;
          state_next = ST_HI;
        end else begin
          state_next = ST_INIT;
        end
      end
      ST_HI: begin
        cmd.op     = OP_SRCH_TEST;
        state_next = status.hit ? ST_INIT : ST_CHK;
      end
      ST_INIT: begin
        cmd.op     = OP_INIT;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.op     = OP_STEP_BEGIN;
        state_next = ST_POS;
      end
      ST_POS: begin
        if (status.pos_active) begin
          cmd.op     = OP_POS_READ;
          state_next = ST_RDA;
        end else begin
          cmd.op     = OP_SHIFT;
          state_next = status.pos_last ? ST_NEXT : ST_POS;
        end
      end
      ST_RDA: begin
        cmd.op     = OP_RDA;
        state_next = ST_RDB;
      end
      ST_RDB: begin
        cmd.op     = OP_RDB;
        state_next = ST_RDC;
      end
      ST_RDC: begin
        cmd.op     = OP_RDC;
        state_next = ST_RDD;
      end
      ST_RDD: begin
        cmd.op     = OP_RDD;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_GO_A;
      end
      ST_GO_A: begin
        cmd.op     = OP_DIV_GO;
        state_next = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (status.div_done) begin
          cmd.op     = OP_TERM_A;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_GO_B;
      end
      ST_GO_B: begin
        cmd.op     = OP_DIV_GO;
        state_next = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (status.div_done) begin
          cmd.op     = OP_UPDATE;
          state_next = status.pos_last ? ST_NEXT : ST_POS;
        end
      end
      ST_NEXT: begin
        if (status.step_last) begin
          cmd.op     = OP_FINAL;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_STEP_INC;
          state_next = ST_STEP;
        end
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (status.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/bspline_basis_weights_unit.sv @@
// Knot load: taken in the idle state, no result, the next word may follow at once.
// Evaluate: a search over the knot spans, then per recurrence step two serial divisions
// for each active weight, then one output word per basis slot. One word at a time.
// Results come one per cycle on result_valid; the receiver cannot stall.
// Synchronous reset restores the config registers and control; the knot store holds garbage until loaded.
`timescale 1ns / 1ps
`include "bspline_basis_weights_unit_defines.svh"

module bspline_basis_weights_unit #(
  parameter int MAX_ORDER = bbw_pkg::MAX_ORDER_DEF,
  parameter int MAX_KNOTS = bbw_pkg::MAX_KNOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [5:0]                  knot_slot,
  input  logic [bbw_pkg::KNOT_W-1:0]  value,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [6:0]                  cfg_data,
  output logic                        result_valid,
  output logic [5:0]                  start_index,
  output logic [bbw_pkg::SLOT_W-1:0]  basis_slot,
  output logic [bbw_pkg::WGT_W-1:0]   weight,
  output logic                        last
);
  import bbw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status)
  );

  bbw_datapath #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_KNOTS (MAX_KNOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .knot_slot    (knot_slot),
    .value        (value),
    .result_valid (result_valid),
    .start_index  (start_index),
    .basis_slot   (basis_slot),
    .weight       (weight),
    .last         (last)
  );

  `BBW_ASSERT(a_eval_goes_busy, start && !busy && operation |=> busy, "evaluate not started")
  `BBW_ASSERT(a_load_no_word, start && !busy && !operation |=> !busy && !result_valid, "load gave a word")
  `BBW_ASSERT(a_slot_runs, result_valid && !last |=> result_valid && basis_slot == $past(basis_slot) + 3'd1, "weight words broken")
  `BBW_ASSERT_ALWAYS(a_weight_range, result_valid |-> weight <= ONE_Q16, "weight above one")

endmodule
